// File: src/mrwt_pkg.sv
// Shared constants for the Miller-Rabin witness test core.
// Holds the sequencer state codes and product destinations; no dependencies.
package mrwt_pkg;

	localparam int STATE_W = 3;

	localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
	localparam logic [STATE_W-1:0] ST_REDUCE = 3'd1;
	localparam logic [STATE_W-1:0] ST_POW    = 3'd2;
	localparam logic [STATE_W-1:0] ST_MUL    = 3'd3;
	localparam logic [STATE_W-1:0] ST_CHECK  = 3'd4;

	// Destination of a finished modular product.
	localparam logic DST_ACC  = 1'b0;
	localparam logic DST_BASE = 1'b1;

endpackage

// File: src/miller_rabin_witness_test_core.sv
// Miller-Rabin single-base witness test with a bit-serial modular multiplier.
// Depends on mrwt_pkg for state codes and product destinations.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------
//  request | start, accepted when !busy  | base[31:0], candidate[31:0]
//  verdict | done, one-cycle strobe      | probably_prime, invalid
//
// A candidate below two gives its verdict in the cycle after the transfer.
// Otherwise the base is reduced modulo the candidate one bit per cycle (OW = min(WIDTH, 32))
// while candidate-1 is split into d * 2^k at the same time.
// Each modular product is set up in the state before it, adds and doubles once per multiplier
// bit until the multiplier is zero, then finishes; at most 2*OW - 2 products follow the reduction.
// One item is in work at a time; reset returns the sequencer to idle and done is never stalled.
module miller_rabin_witness_test_core #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] base,
	input  logic [31:0] candidate,
	output logic        done,
	output logic        probably_prime,
	output logic        invalid
);

	localparam int OW = (WIDTH < 32) ? WIDTH : 32;
	localparam int CW = $clog2(OW + 1);
	localparam int KW = $clog2(OW);

	function automatic logic [OW-1:0] add_mod(input logic [OW-1:0] x,
		input logic [OW-1:0] y, input logic [OW-1:0] m);
		logic [OW-1:0] gap;
		gap = m - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	logic [mrwt_pkg::STATE_W-1:0] state_q;
	logic [OW-1:0] m_q, m1_q, e_q, b_q, acc_q, sr_q;
	logic [OW-1:0] mx_q, my_q, macc_q;
	logic [CW-1:0] cnt_q;
	logic [KW-1:0] k_q;
	logic          mdst_q, sq_q;
	logic          done_q, pp_q, inv_q;

	logic [OW-1:0] cand_w;
	logic [OW:0]   rem2;

	assign cand_w = candidate[OW-1:0];
	assign rem2   = {b_q, sr_q[OW-1]};

	assign busy           = (state_q != mrwt_pkg::ST_IDLE);
	assign done           = done_q;
	assign probably_prime = pp_q;
	assign invalid        = inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrwt_pkg::ST_IDLE;
			done_q  <= 1'b0;
			pp_q    <= 1'b0;
			inv_q   <= 1'b0;
			m_q     <= '0;
			m1_q    <= '0;
			e_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
			sr_q    <= '0;
			mx_q    <= '0;
			my_q    <= '0;
			macc_q  <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			mdst_q  <= mrwt_pkg::DST_ACC;
			sq_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				mrwt_pkg::ST_IDLE: begin
					if (start) begin
						if (cand_w[OW-1:1] == '0) begin
							done_q <= 1'b1;
							pp_q   <= 1'b0;
							inv_q  <= 1'b1;
						end else begin
							m_q     <= cand_w;
							m1_q    <= cand_w - OW'(1);
							e_q     <= cand_w - OW'(1);
							k_q     <= '0;
							sr_q    <= base[OW-1:0];
							b_q     <= '0;
							cnt_q   <= CW'(OW);
							sq_q    <= 1'b0;
							state_q <= mrwt_pkg::ST_REDUCE;
						end
					end
				end
				mrwt_pkg::ST_REDUCE: begin
					// Restoring reduction: the remainder stays below the candidate.
					b_q  <= (rem2 >= {1'b0, m_q}) ? OW'(rem2 - {1'b0, m_q}) : rem2[OW-1:0];
					sr_q <= sr_q << 1;
					// Strip the trailing zeros of candidate-1 in the same cycles.
					if (!e_q[0]) begin
						e_q <= e_q >> 1;
						k_q <= k_q + KW'(1);
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						acc_q   <= OW'(1);
						state_q <= mrwt_pkg::ST_POW;
					end
				end
				mrwt_pkg::ST_POW: begin
					// An odd exponent multiplies the accumulator and clears its low
					// bit, so the next visit squares the base and shifts unless the exponent has reached zero.
					if (e_q == '0) begin
						state_q <= mrwt_pkg::ST_CHECK;
					end else if (e_q[0]) begin
						mx_q    <= acc_q;
						my_q    <= b_q;
						macc_q  <= '0;
						mdst_q  <= mrwt_pkg::DST_ACC;
						e_q[0]  <= 1'b0;
						state_q <= mrwt_pkg::ST_MUL;
					end else begin
						mx_q    <= b_q;
						my_q    <= b_q;
						macc_q  <= '0;
						mdst_q  <= mrwt_pkg::DST_BASE;
						e_q     <= e_q >> 1;
						state_q <= mrwt_pkg::ST_MUL;
					end
				end
				mrwt_pkg::ST_MUL: begin
					if (my_q != '0) begin
						if (my_q[0]) begin
							macc_q <= add_mod(macc_q, mx_q, m_q);
						end
						mx_q <= add_mod(mx_q, mx_q, m_q);
						my_q <= my_q >> 1;
					end else begin
						if (mdst_q == mrwt_pkg::DST_BASE) begin
							b_q <= macc_q;
						end else begin
							acc_q <= macc_q;
						end
						state_q <= sq_q ? mrwt_pkg::ST_CHECK : mrwt_pkg::ST_POW;
					end
				end
				mrwt_pkg::ST_CHECK: begin
					// Before any squaring a value of one passes; after one it fails.
					if (acc_q == m1_q) begin
						done_q  <= 1'b1;
						pp_q    <= 1'b1;
						inv_q   <= 1'b0;
						state_q <= mrwt_pkg::ST_IDLE;
					end else if (acc_q == OW'(1)) begin
						done_q  <= 1'b1;
						pp_q    <= !sq_q;
						inv_q   <= 1'b0;
						state_q <= mrwt_pkg::ST_IDLE;
					end else if (k_q <= KW'(1)) begin
						done_q  <= 1'b1;
						pp_q    <= 1'b0;
						inv_q   <= 1'b0;
						state_q <= mrwt_pkg::ST_IDLE;
					end else begin
						k_q     <= k_q - KW'(1);
						sq_q    <= 1'b1;
						mx_q    <= acc_q;
						my_q    <= acc_q;
						macc_q  <= '0;
						mdst_q  <= mrwt_pkg::DST_ACC;
						state_q <= mrwt_pkg::ST_MUL;
					end
				end
				default: begin
					state_q <= mrwt_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/mrwt_checker.sv
// Port-level checks for the Miller-Rabin witness test core.
// Attached to miller_rabin_witness_test_core by the bind at the end of this file.
module mrwt_port_checks (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic probably_prime,
	input logic invalid
);

	// A verdict is only given once the core has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	// An accepted request either starts work or is answered at once.
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transfer produced neither work nor verdict");

	// Work only ends with a verdict.
	a_end_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("core went idle without a verdict");

	// An immediate verdict belongs to an invalid candidate, which never passes.
	a_quick_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		done && !$past(busy) |-> invalid && !probably_prime)
		else $error("immediate verdict not flagged invalid");

endmodule

bind miller_rabin_witness_test_core mrwt_port_checks u_mrwt_port_checks (.*);

// File: test/mrwt_checker.sv
// Checker for the Miller-Rabin witness test core: watches requests and verdicts,
// predicts each verdict from the request and compares in order. Standalone module.
`timescale 1ns / 1ps

module mrwt_checker #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] base,
	input  logic [31:0] candidate,
	input  logic        done,
	input  logic        probably_prime,
	input  logic        invalid,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned verdicts,
	output int unsigned prime_verdicts,
	output int unsigned invalid_verdicts
);

	typedef struct {
		logic [31:0] b;
		logic [31:0] c;
		logic        prime;
		logic        inv;
	} verdict_t;

	verdict_t verdict_q[$];
	verdict_t oldest;

	function automatic logic [63:0] add_mod_w(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [63:0] gap;
		gap = m - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	function automatic logic [63:0] mul_mod_w(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd0;
		while (y != 64'd0) begin
			if (y[0])
				acc = add_mod_w(acc, x, m);
			x = add_mod_w(x, x, m);
			y = y >> 1;
		end
		return acc;
	endfunction

	function automatic logic [63:0] pow_mod_w(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		b = b % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = mul_mod_w(acc, b, m);
			b = mul_mod_w(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic verdict_t predict_verdict(logic [31:0] b_in, logic [31:0] c_in);
		verdict_t    v;
		logic [63:0] mask;
		logic [63:0] bv;
		logic [63:0] cv;
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] m1;
		int          k;
		bit          stop;
		mask = (WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WIDTH) - 64'd1);
		bv = {32'd0, b_in} & mask;
		cv = {32'd0, c_in} & mask;
		v.b = b_in;
		v.c = c_in;
		v.prime = 1'b0;
		v.inv = 1'b0;
		if (cv < 64'd2) begin
			v.inv = 1'b1;
			return v;
		end
		m1 = cv - 64'd1;
		d = m1;
		k = 0;
		while (!d[0]) begin
			d = d >> 1;
			k++;
		end
		x = pow_mod_w(bv, d, cv);
		if (x == 64'd1 || x == m1) begin
			v.prime = 1'b1;
		end else begin
			// At most k-1 squarings; a -1 that only the k-th would reach is a failure.
			stop = 1'b0;
			for (int j = 1; j < k && !stop; j++) begin
				x = mul_mod_w(x, x, cv);
				if (x == 64'd1) begin
					stop = 1'b1;
				end else if (x == m1) begin
					v.prime = 1'b1;
					stop = 1'b1;
				end
			end
		end
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// Push before pop so a verdict in the same cycle still meets the oldest request.
			if (start && !busy)
				verdict_q.push_back(predict_verdict(base, candidate));
			if (done) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("verdict strobe with no request outstanding");
				end else begin
					oldest = verdict_q.pop_front();
					verdicts++;
					if (oldest.prime)
						prime_verdicts++;
					if (oldest.inv)
						invalid_verdicts++;
					if (probably_prime !== oldest.prime)
						report_mismatch($sformatf("probably_prime %b, want %b (base %h candidate %h)",
							probably_prime, oldest.prime, oldest.b, oldest.c));
					if (invalid !== oldest.inv)
						report_mismatch($sformatf("invalid %b, want %b (base %h candidate %h)",
							invalid, oldest.inv, oldest.b, oldest.c));
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

// File: test/tb.sv
// Top of the Miller-Rabin witness test bench: clock, reset, request stimulus and verdict.
// Depends on miller_rabin_witness_test_core and mrwt_checker.
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_REQUESTS = 147;
	localparam int QUIET_TAIL      = 120;
	localparam int LIMIT_CYCLES    = 4_000_000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] base;
	logic [31:0] candidate;
	logic        done;
	logic        probably_prime;
	logic        invalid;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned verdicts;
	int unsigned prime_verdicts;
	int unsigned invalid_verdicts;
	int unsigned cycles;

	logic [31:0] known_primes [8] = '{
		32'd4294967291, 32'd2147483647, 32'd3221225473, 32'd2013265921,
		32'd469762049, 32'd65537, 32'd7919, 32'd97
	};

	miller_rabin_witness_test_core #(.WIDTH(32)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.base(base),
		.candidate(candidate),
		.done(done),
		.probably_prime(probably_prime),
		.invalid(invalid)
	);

	mrwt_checker #(.WIDTH(32)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.base(base),
		.candidate(candidate),
		.done(done),
		.probably_prime(probably_prime),
		.invalid(invalid),
		.mismatches(mismatches),
		.pending(pending),
		.verdicts(verdicts),
		.prime_verdicts(prime_verdicts),
		.invalid_verdicts(invalid_verdicts)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer with start still high.
	task automatic send_request(input logic [31:0] b, input logic [31:0] c);
		start <= 1'b1;
		base <= b;
		candidate <= c;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		base <= $urandom();
		candidate <= $urandom();
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_candidate();
		logic [31:0] c;
		int          k;
		case ($urandom_range(0, 11))
			0: c = $urandom_range(0, 1);
			1, 2: c = known_primes[$urandom_range(0, 7)];
			3: c = $urandom_range(3, 255) | 32'd1;
			4, 5: begin
				// Odd part shifted up by k, so the squaring chain gets long.
				k = $urandom_range(1, 31);
				c = ((($urandom() >> k) | 32'd1) << k) + 32'd1;
				if (c < 32'd3)
					c = 32'd3;
			end
			6: c = $urandom() & ~32'd1;
			7: c = 32'd2;
			8: c = $urandom() | 32'd1;
			default: c = $urandom();
		endcase
		return c;
	endfunction

	function automatic logic [31:0] pick_base(input logic [31:0] c);
		logic [31:0] b;
		case ($urandom_range(0, 9))
			0: b = 32'd0;
			1: b = c;
			2: b = (c < 32'h8000_0000) ? (c << 1) : c;
			3: b = $urandom_range(1, 16);
			4: b = 32'hFFFF_FFFF;
			default: b = $urandom();
		endcase
		return b;
	endfunction

	initial begin
		logic [31:0] c;
		arst_n = 1'b0;
		start = 1'b0;
		base = 32'd0;
		candidate = 32'd0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Invalid candidates, then the candidate two with odd and even bases.
		send_request(32'hFFFF_FFFF, 32'd0);
		send_request(32'h1234_5678, 32'd1);
		send_request(32'd0, 32'd1);
		send_request(32'd3, 32'd2);
		send_request(32'd4, 32'd2);
		send_request(32'hFFFF_FFFF, 32'd2);
		// Even candidates above two: no squaring follows.
		send_request(32'd3, 32'd4);
		send_request(32'd5, 32'd10);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		// Base a multiple of the candidate.
		send_request(32'd97, 32'd97);
		send_request(32'd194, 32'd97);
		send_request(32'd0, 32'd4294967291);
		// Pass at once, pass after squaring, fail on reaching one.
		send_request(32'd2, 32'd4294967291);
		send_request(32'd5, 32'd13);
		send_request(32'd2, 32'd2047);
		send_request(32'd2, 32'd561);
		send_request(32'd2, 32'd221);
		send_request(32'd3, 32'd3221225473);
		send_request(32'd7, 32'd2013265921);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h8000_0001, 32'h8000_0001);
		send_request(32'd1, 32'd3);
		send_request(32'hAAAA_AAAA, 32'h5555_5555);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i < QUIET_TAIL && $urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 16));
			c = pick_candidate();
			send_request(pick_base(c), c);
		end

		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("Covered %0d verdicts: %0d probably prime, %0d invalid candidates.",
			verdicts, prime_verdicts, invalid_verdicts);
		$display("Candidates spanned primes, long 2-power chains, evens, extremes and bases 0 and n.");
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/mrwt_pkg.sv
src/miller_rabin_witness_test_core.sv
src/mrwt_checker.sv
test/mrwt_checker.sv
test/tb.sv
